@@ hw/rtl/crp_pkg.sv @@
// crp_pkg: shared types and character constants of the response parser
`timescale 1ns / 1ps

package crp_pkg;

    // one received item
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       restart;
    } crp_in_t;

    // one result item
    typedef struct packed {
        logic        update_kind;
        logic [31:0] frequency_hz;
        logic [3:0]  mode_digit;
    } crp_out_t;

    // proposed result of the parse stage for the item in its input register
    typedef struct packed {
        logic     emit;
        crp_out_t item;
    } crp_result_t;

    localparam logic KIND_FREQ = 1'b0;
    localparam logic KIND_MODE = 1'b1;

    localparam logic [7:0] CHAR_SEMI = 8'h3B;
    localparam logic [7:0] CHAR_F    = 8'h46;
    localparam logic [7:0] CHAR_A    = 8'h41;
    localparam logic [7:0] CHAR_M    = 8'h4D;
    localparam logic [7:0] CHAR_D    = 8'h44;
    localparam logic [7:0] CHAR_0    = 8'h30;
    localparam logic [7:0] CHAR_1    = 8'h31;
    localparam logic [7:0] CHAR_9    = 8'h39;

    localparam int FA_LEN          = 14;
    localparam int MD_LEN          = 4;
    localparam int DIGIT_FIRST_POS = 2;
    localparam int DIGIT_LAST_POS  = 12;

endpackage

@@ hw/rtl/crp_input_stage.sv @@
// crp_input_stage: input register of the response parser
`timescale 1ns / 1ps

module crp_input_stage
    import crp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  crp_in_t s_data,
    input  logic    take,
    output logic    valid,
    output crp_in_t data
);

    logic    valid_reg;
    crp_in_t data_reg;

    // free, or being emptied this cycle
    assign s_ready = !valid_reg || take;
    assign valid   = valid_reg;
    assign data    = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

endmodule

@@ hw/rtl/crp_parse_core.sv @@
// crp_parse_core: message state and single-pass decode of one byte
`timescale 1ns / 1ps

module crp_parse_core
    import crp_pkg::*;
#(
    parameter int BUFFER_BYTES = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        commit,
    input  crp_in_t     in_item,
    output crp_result_t result
);

    localparam int LEN_W = $clog2(BUFFER_BYTES);

    logic [LEN_W-1:0] len_reg, len_next;
    logic [7:0]       first_reg, first_next;
    logic [7:0]       second_reg, second_next;
    logic [7:0]       third_reg, third_next;
    logic [31:0]      acc_reg, acc_next;
    logic             dvalid_reg, dvalid_next;
    logic [31:0]      last_freq_reg, last_freq_next;
    logic [3:0]       last_mode_reg, last_mode_next;

    logic [LEN_W-1:0] pos;
    logic [LEN_W-1:0] len_inc;
    logic [7:0]       c;
    logic [3:0]       digit_diff;
    logic             is_digit;
    logic             in_span;
    logic [31:0]      acc_mac;
    logic             fa_hit;
    logic             md_hit;

    assign c          = in_item.rx_byte;
    assign digit_diff = 4'(c - CHAR_0);
    assign is_digit   = (c >= CHAR_0) && (c <= CHAR_9);
    assign pos        = (len_reg >= LEN_W'(BUFFER_BYTES - 1)) ? '0 : len_reg;
    assign len_inc    = pos + LEN_W'(1);
    assign in_span    = (pos >= LEN_W'(DIGIT_FIRST_POS)) && (pos <= LEN_W'(DIGIT_LAST_POS));
    // acc * 10 + digit, modulo 2^32
    assign acc_mac    = {acc_reg[28:0], 3'b000} + {acc_reg[30:0], 1'b0}
                        + {28'd0, digit_diff};

    // the terminator sits past the digit span, so the stored fields are final
    assign fa_hit = (c == CHAR_SEMI) && (len_inc == LEN_W'(FA_LEN))
                    && (first_reg == CHAR_F) && (second_reg == CHAR_A)
                    && dvalid_reg && (acc_reg != last_freq_reg);
    assign md_hit = (c == CHAR_SEMI) && (len_inc == LEN_W'(MD_LEN))
                    && (first_reg == CHAR_M) && (second_reg == CHAR_D)
                    && (third_reg >= CHAR_1) && (third_reg <= CHAR_9)
                    && (third_reg[3:0] != last_mode_reg);

    always_comb begin
        len_next       = len_inc;
        first_next     = first_reg;
        second_next    = second_reg;
        third_next     = third_reg;
        acc_next       = acc_reg;
        dvalid_next    = dvalid_reg;
        last_freq_next = last_freq_reg;
        last_mode_next = last_mode_reg;

        if (pos == '0) begin
            first_next  = c;
            acc_next    = '0;
            dvalid_next = 1'b1;
        end else if (pos == LEN_W'(1)) begin
            second_next = c;
        end
        if (pos == LEN_W'(DIGIT_FIRST_POS)) begin
            third_next = c;
        end
        if (in_span) begin
            if (is_digit) begin
                acc_next = acc_mac;
            end else begin
                dvalid_next = 1'b0;
            end
        end
        if (c == CHAR_SEMI) begin
            len_next = '0;
        end
        if (fa_hit) begin
            last_freq_next = acc_reg;
        end
        if (md_hit) begin
            last_mode_next = third_reg[3:0];
        end
    end

    always_comb begin
        result                   = '0;
        result.emit              = !in_item.restart && (fa_hit || md_hit);
        if (md_hit) begin
            result.item.update_kind = KIND_MODE;
            result.item.mode_digit  = third_reg[3:0];
        end else begin
            result.item.update_kind  = KIND_FREQ;
            result.item.frequency_hz = acc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (commit && in_item.restart)) begin
            len_reg       <= '0;
            first_reg     <= '0;
            second_reg    <= '0;
            third_reg     <= '0;
            acc_reg       <= '0;
            dvalid_reg    <= 1'b1;
            last_freq_reg <= '0;
            last_mode_reg <= '0;
        end else if (commit) begin
            len_reg       <= len_next;
            first_reg     <= first_next;
            second_reg    <= second_next;
            third_reg     <= third_next;
            acc_reg       <= acc_next;
            dvalid_reg    <= dvalid_next;
            last_freq_reg <= last_freq_next;
            last_mode_reg <= last_mode_next;
        end
    end

endmodule

@@ hw/rtl/crp_output_stage.sv @@
// crp_output_stage: result register of the response parser
`timescale 1ns / 1ps

module crp_output_stage
    import crp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     load,
    input  crp_out_t load_data,
    output logic     free,
    output logic     m_valid,
    input  logic     m_ready,
    output crp_out_t m_data
);

    logic     valid_reg;
    crp_out_t data_reg;

    assign free    = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (free) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && free) begin
            data_reg <= load_data;
        end
    end

endmodule

@@ hw/rtl/cat_response_parser.sv @@
// cat_response_parser: top level of the serial control response parser
`timescale 1ns / 1ps

// usage
// - s_ channel: one received character per item (s_data.rx_byte); with
//   s_data.restart set the character is dropped and all message state and
//   cached frequency / mode values go back to their reset values
// - m_ channel: one item each time a complete FA frequency or MD mode response
//   carries a value that differs from the last one of its kind
// - path: an item in the input register is parsed and, if it gives a result, is
//   loaded into the result register once that has room; m_valid rises with the load
// - throughput: one item per cycle, except while a result waits for the result register; the parse is a single pass of
//   a few compares and one multiply-by-ten add between input and result registers
// - reset (aresetn low, synchronous): both registers empty, parser state cleared
// - receiver stall: the result register holds its item; the input register
//   keeps taking items that give no result, and one that would give a result
//   waits in the input register, so s_ready drops only then
module cat_response_parser
    import crp_pkg::*;
#(
    parameter int BUFFER_BYTES = 128
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  crp_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output crp_out_t m_data
);

    logic        in_valid;
    crp_in_t     in_item;
    crp_result_t res;
    logic        out_free;
    logic        fire;

    // an item leaves the input register when its result, if any, has room
    assign fire = in_valid && (!res.emit || out_free);

    crp_input_stage u_input (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .take    (fire),
        .valid   (in_valid),
        .data    (in_item)
    );

    // message length counter, stored characters, digit accumulator and cached values
    crp_parse_core #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .commit  (fire),
        .in_item (in_item),
        .result  (res)
    );

    crp_output_stage u_output (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (fire && res.emit),
        .load_data (res.item),
        .free      (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // a restart item never produces a result
    a_restart_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_item.restart) |-> !res.emit)
        else $error("restart item produced a result");

    // an item that cannot move on stays put in the input register
    a_input_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && !fire) |=> (in_valid && $stable(in_item)))
        else $error("input register lost a stalled item");

    // a parsed result always lands in the result register
    a_result_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && res.emit) |=> m_valid)
        else $error("parsed result did not reach the result register");

    // the input side backs off only while an item waits in the input register
    a_ready_low: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid && res.emit && !m_ready))
        else $error("s_ready low without a waiting result");

endmodule
